[rtl/core/rcpa_pkg.sv]
// ----------------------------------------------------------------------------
// rcpa_pkg
// shared types, request codes and helpers for the per-cpu page allocator
// ----------------------------------------------------------------------------
package rcpa_pkg;

    localparam int CPU_MAX_W  = 6;
    localparam int PAGE_MAX_W = 20;
    localparam int COUNT_W    = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] REQ_ALLOC = 3'd0;
    localparam logic [2:0] REQ_FREE  = 3'd1;
    localparam logic [2:0] REQ_INC   = 3'd2;
    localparam logic [2:0] REQ_DEC   = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;
    localparam logic [2:0] REQ_BYTES = 3'd5;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_OOM    = 2'd1,
        STAT_BAD    = 2'd2,
        STAT_SHARED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_INC,
        OP_DEC,
        OP_READ,
        OP_REPORT
    } op_t;

    typedef struct packed {
        op_t                   op;
        status_t               status;
        logic [CPU_MAX_W-1:0]  cpu;
        logic [PAGE_MAX_W-1:0] page;
    } cmd_t;

    // cpu number folded into the cpu count by repeated subtraction
    function automatic logic [CPU_MAX_W-1:0] cpu_fold(input logic [2:0] v, input int n);
        logic [CPU_MAX_W:0] r;
        r = (CPU_MAX_W+1)'(v);
        for (int i = 0; i < 8; i++)
        begin
            if (r >= (CPU_MAX_W+1)'(n))
            begin
                r = r - (CPU_MAX_W+1)'(n);
            end
        end
        return r[CPU_MAX_W-1:0];
    endfunction

endpackage

[rtl/core/rcpa_front.sv]
// ----------------------------------------------------------------------------
// rcpa_front
// request intake: holds the kernel end register, checks addresses and
// turns each request beat into a decoded command for the queue
// ----------------------------------------------------------------------------
module rcpa_front #(
    parameter int NUM_CPUS   = 8,
    parameter int MEM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [26:0]       kernel_end_offset,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [2:0]        req_type,
    input  logic [2:0]        cpu_id,
    input  logic [27:0]       addr,
    input  logic              clear_busy,
    input  logic              q_full,
    output logic              q_push,
    output rcpa_pkg::cmd_t    cmd
);
    import rcpa_pkg::*;

    localparam int OFF_W = $clog2(PAGE_BYTES);
    localparam logic [63:0] MEM_BYTES = 64'(MEM_PAGES) * 64'(PAGE_BYTES);

    logic [26:0] kend_reg;
    logic        in_range;
    logic        aligned;
    logic        below_kernel;
    logic [27:0] addr_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kend_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            kend_reg <= kernel_end_offset;
        end
    end

    assign cfg_ready = 1'b1;
    assign req_ready = !clear_busy && !q_full;
    assign q_push    = req_valid && req_ready;

    assign in_range     = 64'(addr) < MEM_BYTES;
    assign aligned      = addr[OFF_W-1:0] == '0;
    assign below_kernel = addr < {1'b0, kend_reg};
    assign addr_sh      = addr >> OFF_W;

    always_comb
    begin
        cmd.cpu    = cpu_fold(cpu_id, NUM_CPUS);
        cmd.page   = addr_sh[PAGE_MAX_W-1:0];
        cmd.status = STAT_OK;
        cmd.op     = OP_REPORT;
        unique case (req_type)
            REQ_ALLOC: cmd.op = OP_ALLOC;
            REQ_FREE:
            begin
                if (in_range && aligned && !below_kernel)
                begin
                    cmd.op = OP_FREE;
                end
                else
                begin
                    cmd.status = STAT_BAD;
                end
            end
            REQ_INC, REQ_DEC, REQ_READ:
            begin
                if (!in_range)
                begin
                    cmd.status = STAT_BAD;
                end
                else if (req_type == REQ_INC)
                begin
                    cmd.op = OP_INC;
                end
                else if (req_type == REQ_DEC)
                begin
                    cmd.op = OP_DEC;
                end
                else
                begin
                    cmd.op = OP_READ;
                end
            end
            default: cmd.op = OP_REPORT;
        endcase
    end

endmodule

[rtl/core/rcpa_queue.sv]
// ----------------------------------------------------------------------------
// rcpa_queue
// two-entry command queue between intake and execution
// ----------------------------------------------------------------------------
module rcpa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rcpa_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           q_valid,
    output logic           q_full,
    output rcpa_pkg::cmd_t q_cmd
);
    import rcpa_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W:0]       fill_reg;

    assign q_valid = fill_reg != '0;
    assign q_full  = fill_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/rcpa_back.sv]
// ----------------------------------------------------------------------------
// rcpa_back
// execution: per-cpu list heads, link and count memories, free page
// counter, clearing sweep of the count memory and the response register
// ----------------------------------------------------------------------------
module rcpa_back #(
    parameter int NUM_CPUS   = 8,
    parameter int MEM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  rcpa_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           clear_busy,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output logic [1:0]     status,
    output logic [26:0]    page_addr,
    output logic [15:0]    ref_count,
    output logic [27:0]    free_bytes
);
    import rcpa_pkg::*;

    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int PAGE_W = $clog2(MEM_PAGES);
    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int TOT_W  = $clog2(MEM_PAGES + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                state_reg;
    logic                  clr_active_reg;
    logic [PAGE_W-1:0]     clr_idx_reg;
    logic [NUM_CPUS-1:0]   nonempty_reg;
    logic [NUM_CPUS-1:0]   nonempty_next;
    logic [TOT_W-1:0]      total_reg;
    logic [TOT_W-1:0]      total_next;
    logic                  rsp_valid_reg;

    logic [PAGE_W-1:0]     head_reg [NUM_CPUS];
    logic [PAGE_W:0]       link_mem [MEM_PAGES];
    logic [COUNT_W-1:0]    cnt_mem  [MEM_PAGES];
    logic [PAGE_W:0]       link_rd_reg;
    logic [COUNT_W-1:0]    cnt_rd_reg;

    op_t                   op_reg;
    status_t               stat_reg;
    logic [CPU_W-1:0]      cpu_reg;
    logic [PAGE_W-1:0]     page_reg;

    logic [1:0]            status_reg;
    logic [26:0]           page_addr_reg;
    logic [15:0]           ref_count_reg;
    logic [27:0]           free_bytes_reg;

    logic                  issue;
    logic                  done;
    logic [CPU_W-1:0]      own;
    logic [CPU_W-1:0]      low_idx;
    logic                  found;
    logic [CPU_W-1:0]      sel;
    op_t                   op_issue;
    status_t               stat_issue;

    logic [COUNT_W-1:0]    cnt_new;
    logic                  cnt_we;
    logic [PAGE_W-1:0]     cnt_waddr;
    logic [COUNT_W-1:0]    cnt_wdata;
    logic                  push_page;
    logic [PAGE_W:0]       link_wdata;
    status_t               stat_out;
    logic [COUNT_W-1:0]    ref_out;
    logic [63:0]           pa_wide;
    logic [63:0]           fb_wide;

    assign clear_busy = clr_active_reg;
    assign issue      = (state_reg == ST_IDLE) && !clr_active_reg && q_valid;
    assign q_pop      = issue;
    assign done       = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign own        = q_cmd.cpu[CPU_W-1:0];

    always_comb
    begin
        low_idx = '0;
        found   = 1'b0;
        for (int i = NUM_CPUS - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                low_idx = CPU_W'(i);
                found   = 1'b1;
            end
        end
        sel = nonempty_reg[own] ? own : low_idx;
    end

    always_comb
    begin
        op_issue   = q_cmd.op;
        stat_issue = q_cmd.status;
        if (q_cmd.op == OP_ALLOC && !found)
        begin
            op_issue   = OP_REPORT;
            stat_issue = STAT_OOM;
        end
    end

    // execute stage
    always_comb
    begin
        cnt_new       = cnt_rd_reg;
        push_page     = 1'b0;
        stat_out      = STAT_OK;
        ref_out       = '0;
        nonempty_next = nonempty_reg;
        total_next    = total_reg;
        pa_wide       = '0;
        case (op_reg)
            OP_ALLOC:
            begin
                cnt_new                = COUNT_W'(1);
                ref_out                = COUNT_W'(1);
                nonempty_next[cpu_reg] = link_rd_reg[PAGE_W];
                total_next             = (total_reg == '0) ? total_reg : total_reg - 1'b1;
                pa_wide                = 64'(page_reg) << OFF_W;
            end
            OP_FREE:
            begin
                cnt_new = (cnt_rd_reg == '0) ? cnt_rd_reg : cnt_rd_reg - 1'b1;
                ref_out = cnt_new;
                if (cnt_new != '0)
                begin
                    stat_out = STAT_SHARED;
                end
                else
                begin
                    push_page              = 1'b1;
                    nonempty_next[cpu_reg] = 1'b1;
                    total_next = (total_reg < TOT_W'(MEM_PAGES)) ? total_reg + 1'b1
                                                                 : total_reg;
                end
            end
            OP_INC:
            begin
                cnt_new = (cnt_rd_reg == '1) ? cnt_rd_reg : cnt_rd_reg + 1'b1;
                ref_out = cnt_new;
            end
            OP_DEC:
            begin
                cnt_new = (cnt_rd_reg == '0) ? cnt_rd_reg : cnt_rd_reg - 1'b1;
                ref_out = cnt_new;
            end
            OP_READ: ref_out = cnt_rd_reg;
            default: stat_out = stat_reg;
        endcase
        fb_wide = 64'(total_next) << OFF_W;
    end

    assign link_wdata = nonempty_reg[cpu_reg] ? {1'b1, head_reg[cpu_reg]} : '0;

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = page_reg;
        cnt_wdata = cnt_new;
        if (clr_active_reg)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_idx_reg;
            cnt_wdata = '0;
        end
        else if (done && (op_reg == OP_ALLOC || op_reg == OP_FREE ||
                          op_reg == OP_INC || op_reg == OP_DEC))
        begin
            cnt_we = 1'b1;
        end
    end

    // memories, list heads, issue and response payload
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (done && push_page)
        begin
            link_mem[page_reg] <= link_wdata;
        end
        if (issue)
        begin
            cnt_rd_reg  <= cnt_mem[q_cmd.page[PAGE_W-1:0]];
            link_rd_reg <= link_mem[head_reg[sel]];
            op_reg      <= op_issue;
            stat_reg    <= stat_issue;
            cpu_reg     <= (q_cmd.op == OP_ALLOC) ? sel : own;
            page_reg    <= (q_cmd.op == OP_ALLOC) ? head_reg[sel]
                                                  : q_cmd.page[PAGE_W-1:0];
        end
        if (done && op_reg == OP_ALLOC)
        begin
            head_reg[cpu_reg] <= link_rd_reg[PAGE_W-1:0];
        end
        else if (done && push_page)
        begin
            head_reg[cpu_reg] <= page_reg;
        end
        if (done)
        begin
            status_reg     <= stat_out;
            page_addr_reg  <= pa_wide[26:0];
            ref_count_reg  <= ref_out;
            free_bytes_reg <= fb_wide[27:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            nonempty_reg   <= '0;
            total_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == PAGE_W'(MEM_PAGES - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (issue)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (done)
                    begin
                        state_reg    <= ST_IDLE;
                        nonempty_reg <= nonempty_next;
                        total_reg    <= total_next;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (done)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign page_addr  = page_addr_reg;
    assign ref_count  = ref_count_reg;
    assign free_bytes = free_bytes_reg;

`ifndef ASSERT_OFF
    a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TOT_W'(MEM_PAGES))
        else $error("free page counter above page count");
    a_no_issue_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !q_pop)
        else $error("command issued during clearing sweep");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> rsp_valid_reg)
        else $error("completed command left no response");
    a_alloc_list: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && q_cmd.op == OP_ALLOC && found) |-> nonempty_reg[sel])
        else $error("allocation picked an empty list");
`endif

endmodule

[rtl/core/refcounted_percpu_page_allocator.sv]
// ----------------------------------------------------------------------------
// refcounted_percpu_page_allocator
// page allocator with one lifo free list per cpu and a count per page
// ----------------------------------------------------------------------------
// In the execution unit a request first reads the link or count memory, then
// writes it back and loads the response register; a two-entry queue after
// the intake lets requests arrive while one is in execution. A waiting
// response holds the execution unit, and once the queue is full it holds
// intake as well. After reset the count memory is swept to zero, one page a
// cycle, and req_ready stays low until the sweep ends. PAGE_BYTES must be a
// power of two.
module refcounted_percpu_page_allocator #(
    parameter int NUM_CPUS   = 8,
    parameter int MEM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [26:0] kernel_end_offset,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  req_type,
    input  logic [2:0]  cpu_id,
    input  logic [27:0] addr,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [1:0]  status,
    output logic [26:0] page_addr,
    output logic [15:0] ref_count,
    output logic [27:0] free_bytes
);
    import rcpa_pkg::*;

    cmd_t push_cmd;
    cmd_t q_cmd;
    logic q_push;
    logic q_pop;
    logic q_valid;
    logic q_full;
    logic clear_busy;

    rcpa_front #(
        .NUM_CPUS   (NUM_CPUS),
        .MEM_PAGES  (MEM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .kernel_end_offset (kernel_end_offset),
        .req_valid         (req_valid),
        .req_ready         (req_ready),
        .req_type          (req_type),
        .cpu_id            (cpu_id),
        .addr              (addr),
        .clear_busy        (clear_busy),
        .q_full            (q_full),
        .q_push            (q_push),
        .cmd               (push_cmd)
    );

    rcpa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .q_cmd    (q_cmd)
    );

    rcpa_back #(
        .NUM_CPUS   (NUM_CPUS),
        .MEM_PAGES  (MEM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .clear_busy (clear_busy),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .status     (status),
        .page_addr  (page_addr),
        .ref_count  (ref_count),
        .free_bytes (free_bytes)
    );

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the per-cpu refcounted page allocator: random and
// directed requests, idling on both channels, results compared against an
// internal model of the free lists, page counts and free page total
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpa_pkg::*;

    localparam int          CPUS      = 8;
    localparam int          PAGES     = 32768;
    localparam int          PG_BYTES  = 4096;
    localparam logic [2:0]  REQ_SPARE_A = 3'd6;
    localparam logic [2:0]  REQ_SPARE_B = 3'd7;
    localparam logic [26:0] KEND_MAX  = 27'h7FFFFFF;

    typedef struct {
        status_t     status;
        logic [26:0] page_addr;
        logic [15:0] ref_count;
        logic [27:0] free_bytes;
    } answer_t;

    class page_scoreboard;
        logic [15:0] counts[PAGES];
        logic [14:0] links[PAGES];
        bit          link_ok[PAGES];
        logic [14:0] heads[CPUS];
        bit          nonempty[CPUS];
        int          free_pages;
        logic [26:0] kend;
        answer_t     awaited[$];
        int          errors;

        function new();
            foreach (counts[i])
            begin
                counts[i] = '0;
                link_ok[i] = 0;
            end
            foreach (nonempty[i])
            begin
                nonempty[i] = 0;
            end
            free_pages = 0;
            kend = '0;
            errors = 0;
        endfunction

        function bit pop_page(int c, output int p);
            if (!nonempty[c])
            begin
                return 0;
            end
            p = heads[c];
            nonempty[c] = link_ok[p];
            heads[c] = links[p];
            if (free_pages > 0)
            begin
                free_pages--;
            end
            return 1;
        endfunction

        function void push_page(int c, int p);
            link_ok[p] = nonempty[c];
            links[p] = nonempty[c] ? heads[c] : '0;
            heads[c] = p[14:0];
            nonempty[c] = 1;
            if (free_pages < PAGES)
            begin
                free_pages++;
            end
        endfunction

        function void note_request(logic [2:0] req, logic [2:0] cpu, logic [27:0] addr);
            answer_t a;
            bit      got;
            bit      in_range;
            int      p;
            int      pg;
            a.status = STAT_OK;
            a.page_addr = '0;
            a.ref_count = '0;
            in_range = (addr[27] == 1'b0);
            pg = in_range ? int'(addr[26:12]) : 0;
            p = 0;
            case (req)
                REQ_ALLOC:
                begin
                    got = pop_page(cpu, p);
                    for (int i = 0; !got && i < CPUS; i++)
                    begin
                        if (i != cpu)
                        begin
                            got = pop_page(i, p);
                        end
                    end
                    if (got)
                    begin
                        counts[p] = 16'd1;
                        a.page_addr = 27'(p * PG_BYTES);
                        a.ref_count = 16'd1;
                    end
                    else
                    begin
                        a.status = STAT_OOM;
                    end
                end
                REQ_FREE:
                begin
                    if (!in_range || addr[11:0] != 0 || addr < {1'b0, kend})
                    begin
                        a.status = STAT_BAD;
                    end
                    else
                    begin
                        if (counts[pg] > 0)
                        begin
                            counts[pg]--;
                        end
                        a.ref_count = counts[pg];
                        if (counts[pg] > 0)
                        begin
                            a.status = STAT_SHARED;
                        end
                        else
                        begin
                            push_page(cpu, pg);
                        end
                    end
                end
                REQ_INC, REQ_DEC, REQ_READ:
                begin
                    if (!in_range)
                    begin
                        a.status = STAT_BAD;
                    end
                    else
                    begin
                        if (req == REQ_INC && counts[pg] != 16'hFFFF)
                        begin
                            counts[pg]++;
                        end
                        else if (req == REQ_DEC && counts[pg] > 0)
                        begin
                            counts[pg]--;
                        end
                        a.ref_count = counts[pg];
                    end
                end
                default:
                begin
                end
            endcase
            a.free_bytes = 28'(free_pages * PG_BYTES);
            awaited.push_back(a);
        endfunction

        function void check_answer(logic [1:0] st, logic [26:0] pa, logic [15:0] rc,
                                   logic [27:0] fb);
            answer_t a;
            if (awaited.size() == 0)
            begin
                $error("unexpected response beat");
                errors++;
                return;
            end
            a = awaited.pop_front();
            if (st !== a.status)
            begin
                $error("status: expected %0d, got %0d", a.status, st);
                errors++;
            end
            if (pa !== a.page_addr)
            begin
                $error("page_addr: expected %h, got %h", a.page_addr, pa);
                errors++;
            end
            if (rc !== a.ref_count)
            begin
                $error("ref_count: expected %0d, got %0d", a.ref_count, rc);
                errors++;
            end
            if (fb !== a.free_bytes)
            begin
                $error("free_bytes: expected %h, got %h", a.free_bytes, fb);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [26:0] kernel_end_offset;
    logic        req_valid;
    logic        req_ready;
    logic [2:0]  req_type;
    logic [2:0]  cpu_id;
    logic [27:0] addr;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [1:0]  status;
    logic [26:0] page_addr;
    logic [15:0] ref_count;
    logic [27:0] free_bytes;

    page_scoreboard sb;
    bit             no_idle;

    refcounted_percpu_page_allocator uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .kernel_end_offset(kernel_end_offset),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_type(req_type),
        .cpu_id(cpu_id),
        .addr(addr),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .status(status),
        .page_addr(page_addr),
        .ref_count(ref_count),
        .free_bytes(free_bytes)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_request(logic [2:0] req, logic [2:0] cpu, logic [27:0] a);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type <= req;
        cpu_id <= cpu;
        addr <= a;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        sb.note_request(req, cpu, a);
    endtask

    task automatic write_kend(logic [26:0] v);
        req_valid <= 1'b0;
        while (sb.awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        kernel_end_offset <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.kend = v;
    endtask

    function automatic logic [27:0] pick_addr();
        int pg;
        int k;
        pg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, PAGES - 1) : $urandom_range(0, 63);
        k = $urandom_range(0, 9);
        if (k == 0)
        begin
            return 28'($urandom);
        end
        if (k == 1)
        begin
            return 28'(pg * PG_BYTES + $urandom_range(1, PG_BYTES - 1));
        end
        return 28'(pg * PG_BYTES);
    endfunction

    task automatic random_phase(int n);
        int          w;
        logic [2:0]  req;
        for (int i = 0; i < n; i++)
        begin
            w = $urandom_range(0, 99);
            if (w < 32)
                req = REQ_ALLOC;
            else if (w < 64)
                req = REQ_FREE;
            else if (w < 74)
                req = REQ_INC;
            else if (w < 84)
                req = REQ_DEC;
            else if (w < 92)
                req = REQ_READ;
            else if (w < 96)
                req = REQ_BYTES;
            else
                req = w[0] ? REQ_SPARE_A : REQ_SPARE_B;
            send_request(req, 3'($urandom), pick_addr());
        end
    endtask

    initial
    begin
        int stall;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            sb.check_answer(status, page_addr, ref_count, free_bytes);
        end
    end

    initial
    begin
        sb = new();
        no_idle = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        kernel_end_offset = '0;
        req_valid = 1'b0;
        req_type = REQ_ALLOC;
        cpu_id = '0;
        addr = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_kend('0);
        send_request(REQ_FREE, 3'd0, 28'(5 * PG_BYTES));
        send_request(REQ_FREE, 3'd0, 28'(6 * PG_BYTES));
        send_request(REQ_FREE, 3'd3, 28'(7 * PG_BYTES));
        send_request(REQ_BYTES, 3'd4, 28'hFFFFFFF);
        send_request(REQ_ALLOC, 3'd0, '0);
        send_request(REQ_ALLOC, 3'd1, '0);
        send_request(REQ_ALLOC, 3'd2, '0);
        send_request(REQ_ALLOC, 3'd0, '0);
        send_request(REQ_FREE, 3'd0, 28'(5 * PG_BYTES + 1));
        send_request(REQ_FREE, 3'd0, 28'h8000000);
        send_request(REQ_INC, 3'd0, 28'(5 * PG_BYTES));
        send_request(REQ_FREE, 3'd5, 28'(5 * PG_BYTES));
        send_request(REQ_DEC, 3'd0, 28'(5 * PG_BYTES));
        send_request(REQ_DEC, 3'd0, 28'(5 * PG_BYTES));
        send_request(REQ_FREE, 3'd7, 28'(5 * PG_BYTES));
        send_request(REQ_FREE, 3'd7, 28'(5 * PG_BYTES));
        send_request(REQ_READ, 3'd2, 28'h8000000);
        send_request(REQ_READ, 3'd2, 28'(6 * PG_BYTES + 12'hFFF));
        send_request(REQ_INC, 3'd6, 28'hFFFFFFF);
        send_request(REQ_SPARE_A, 3'd1, 28'h7FFF000);
        send_request(REQ_SPARE_B, 3'd2, 28'h0001000);
        send_request(REQ_ALLOC, 3'd7, '0);
        send_request(REQ_FREE, 3'd1, 28'(PAGES - 1) * 28'(PG_BYTES));
        send_request(REQ_READ, 3'd4, 28'(9 * PG_BYTES));

        random_phase(390);
        write_kend(27'(20 * PG_BYTES));
        send_request(REQ_FREE, 3'd0, 28'(3 * PG_BYTES));
        random_phase(390);
        write_kend(KEND_MAX);
        random_phase(380);
        write_kend(27'($urandom_range(0, 64 * PG_BYTES)));
        random_phase(390);

        req_valid <= 1'b0;
        while (sb.awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
